// ===== sv/circular_list_engine_assert.svh =====
// assertion macros for the circular list engine checker
// expects i_clk and i_rst_n in the scope of use
`ifndef CIRCULAR_LIST_ENGINE_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define CLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cle_pkg.sv =====
// shared types, constants and helpers for the circular list engine
// no dependencies
package cle_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD  = 3'd0,
        ACT_INS_TAIL  = 3'd1,
        ACT_DEL_HEAD  = 3'd2,
        ACT_DEL_TAIL  = 3'd3,
        ACT_DEL_VALUE = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic              val_we;
        logic [SLOT_W-1:0] val_waddr;
        logic [DATA_W-1:0] val_wdata;
        logic              nxt_we;
        logic [SLOT_W-1:0] nxt_waddr;
        logic [SLOT_W-1:0] nxt_wdata;
        logic [SLOT_W-1:0] val_raddr;
        logic [SLOT_W-1:0] nxt_raddr;
    } t_mem_req;

    // lowest set bit of the free map
    function automatic logic [SLOT_W-1:0] first_free(input logic [CAPACITY-1:0] map);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/circular_list_engine.sv =====
// circular singly linked list engine, top level
// node pool with free map, link walker sequencer and output register
// depends on cle_pkg and cle_node_mem
//
// input channel i_in_valid/o_in_ready carries one beat per operation
// (i_action, i_value); output channel o_out_valid/i_out_ready returns one
// beat per operation with status, node count, head and tail values
// one operation is in flight at a time; o_in_ready is high only while idle
// a refused or empty-list operation goes straight to the result step; an insert writes the
// new node and, unless the list was empty, then links it after the tail; delete head relinks
// the tail to the second node and fetches its value; delete tail and delete by value walk
// the list from the head; each operation ends in the result step that loads the output register
// the walk reads one next link per cycle from the link memory port
// the output register holds a result until taken, so the next operation
// may be accepted while it waits; a result stalled behind a held one waits
// reset empties the list and marks every slot free, no clearing pass
module circular_list_engine import cle_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_count,
    output logic signed [DATA_W-1:0]   o_head_value,
    output logic signed [DATA_W-1:0]   o_tail_value,
    output logic                       o_is_empty
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INS    = 9'b000000010,
        S_DH     = 9'b000000100,
        S_DH_VAL = 9'b000001000,
        S_DT     = 9'b000010000,
        S_DT_VAL = 9'b000100000,
        S_DV_A   = 9'b001000000,
        S_DV_B   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [CAPACITY-1:0] r_free, n_free;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [DATA_W-1:0] r_hval, n_hval;
    logic [DATA_W-1:0] r_tval, n_tval;
    logic [DATA_W-1:0] r_val, n_val;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_is_tail, n_is_tail;
    logic [SLOT_W-1:0] r_p, n_p;
    logic [DATA_W-1:0] r_pval, n_pval;
    logic [SLOT_W-1:0] r_q, n_q;
    logic [CNT_W-1:0]  r_n, n_n;
    t_status           r_status, n_status;

    logic              r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [COUNT_W-1:0] r_o_count, n_o_count;
    logic [DATA_W-1:0] r_o_hval, n_o_hval;
    logic [DATA_W-1:0] r_o_tval, n_o_tval;
    logic              r_o_empty, n_o_empty;

    t_mem_req          w_req;
    logic [DATA_W-1:0] w_val_rdata;
    logic [SLOT_W-1:0] w_nxt_rdata;
    logic              w_full;
    logic              w_empty;
    logic              w_one;
    logic [SLOT_W-1:0] w_slot;
    t_action           w_act;

    cle_node_mem u_mem (
        .i_clk       (i_clk),
        .i_req       (w_req),
        .o_val_rdata (w_val_rdata),
        .o_nxt_rdata (w_nxt_rdata)
    );

    assign w_full  = (r_free == '0);
    assign w_slot  = first_free(r_free);
    assign w_empty = (r_count == '0);
    assign w_one   = (r_count == CNT_W'(1));
    assign w_act   = t_action'(i_action);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_count     = r_count;
        n_tail      = r_tail;
        n_head      = r_head;
        n_hval      = r_hval;
        n_tval      = r_tval;
        n_val       = r_val;
        n_slot      = r_slot;
        n_is_tail   = r_is_tail;
        n_p         = r_p;
        n_pval      = r_pval;
        n_q         = r_q;
        n_n         = r_n;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        n_o_hval    = r_o_hval;
        n_o_tval    = r_o_tval;
        n_o_empty   = r_o_empty;

        w_req           = '0;
        w_req.val_raddr = w_nxt_rdata;
        w_req.nxt_raddr = w_nxt_rdata;

        case (r_state)
            S_IDLE: begin
                w_req.nxt_raddr = r_head;
                if (i_in_valid) begin
                    n_val    = i_value;
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                    case (w_act)
                        ACT_INS_HEAD, ACT_INS_TAIL: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_req.val_we    = 1'b1;
                                w_req.val_waddr = w_slot;
                                w_req.val_wdata = i_value;
                                w_req.nxt_we    = 1'b1;
                                w_req.nxt_waddr = w_slot;
                                n_free[w_slot]  = 1'b0;
                                n_count         = r_count + CNT_W'(1);
                                n_slot          = w_slot;
                                n_is_tail       = (w_act == ACT_INS_TAIL);
                                if (w_empty) begin
                                    w_req.nxt_wdata = w_slot;
                                    n_tail          = w_slot;
                                    n_head          = w_slot;
                                    n_hval          = i_value;
                                    n_tval          = i_value;
                                end else begin
                                    w_req.nxt_wdata = r_head;
                                    n_state         = S_INS;
                                end
                            end
                        end
                        ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_VALUE: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (w_act == ACT_DEL_HEAD
                                         || (w_act == ACT_DEL_TAIL && w_one)
                                         || (w_act == ACT_DEL_VALUE && r_hval == i_value)) begin
                                if (w_one) begin
                                    n_free[r_head] = 1'b1;
                                    n_count        = '0;
                                    n_tail         = '0;
                                end else begin
                                    n_state = S_DH;
                                end
                            end else if (w_act == ACT_DEL_TAIL) begin
                                n_p     = r_head;
                                n_state = S_DT;
                            end else if (w_one) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_p     = r_head;
                                n_pval  = r_hval;
                                n_n     = CNT_W'(1);
                                n_state = S_DV_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                w_req.nxt_we    = 1'b1;
                w_req.nxt_waddr = r_tail;
                w_req.nxt_wdata = r_slot;
                if (r_is_tail) begin
                    n_tail = r_slot;
                    n_tval = r_val;
                end else begin
                    n_head = r_slot;
                    n_hval = r_val;
                end
                n_state = S_DONE;
            end
            S_DH: begin
                w_req.nxt_we    = 1'b1;
                w_req.nxt_waddr = r_tail;
                w_req.nxt_wdata = w_nxt_rdata;
                n_free[r_head]  = 1'b1;
                n_count         = r_count - CNT_W'(1);
                n_head          = w_nxt_rdata;
                n_state         = S_DH_VAL;
            end
            S_DH_VAL: begin
                n_hval  = w_val_rdata;
                n_state = S_DONE;
            end
            S_DT: begin
                if (w_nxt_rdata == r_tail) begin
                    w_req.nxt_we    = 1'b1;
                    w_req.nxt_waddr = r_p;
                    w_req.nxt_wdata = r_head;
                    w_req.val_raddr = r_p;
                    n_free[r_tail]  = 1'b1;
                    n_tail          = r_p;
                    n_count         = r_count - CNT_W'(1);
                    n_state         = S_DT_VAL;
                end else begin
                    n_p = w_nxt_rdata;
                end
            end
            S_DT_VAL: begin
                n_tval  = w_val_rdata;
                n_state = S_DONE;
            end
            S_DV_A: begin
                n_q     = w_nxt_rdata;
                n_state = S_DV_B;
            end
            S_DV_B: begin
                if (w_val_rdata == r_val) begin
                    w_req.nxt_we    = 1'b1;
                    w_req.nxt_waddr = r_p;
                    w_req.nxt_wdata = w_nxt_rdata;
                    n_free[r_q]     = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                    if (r_q == r_tail) begin
                        n_tail = r_p;
                        n_tval = r_pval;
                    end
                    n_state = S_DONE;
                end else if (r_n + CNT_W'(1) == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_n    = r_n + CNT_W'(1);
                    n_p    = r_q;
                    n_pval = w_val_rdata;
                    n_q    = w_nxt_rdata;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_count   = COUNT_W'(r_count);
                    n_o_hval    = w_empty ? '0 : r_hval;
                    n_o_tval    = w_empty ? '0 : r_tval;
                    n_o_empty   = w_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '1;
            r_count     <= '0;
            r_tail      <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_count     <= n_count;
            r_tail      <= n_tail;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hval     <= n_hval;
        r_tval     <= n_tval;
        r_val      <= n_val;
        r_slot     <= n_slot;
        r_is_tail  <= n_is_tail;
        r_p        <= n_p;
        r_pval     <= n_pval;
        r_q        <= n_q;
        r_n        <= n_n;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_hval   <= n_o_hval;
        r_o_tval   <= n_o_tval;
        r_o_empty  <= n_o_empty;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_count      = r_o_count;
    assign o_head_value = r_o_hval;
    assign o_tail_value = r_o_tval;
    assign o_is_empty   = r_o_empty;

endmodule

// ===== sv/cle_node_mem.sv =====
// node value memory and next-link memory, one write and one read port each
// registered read data; depends on cle_pkg
module cle_node_mem import cle_pkg::*; (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_val_rdata,
    output logic [SLOT_W-1:0] o_nxt_rdata
);

    logic [DATA_W-1:0] r_val_mem [CAPACITY];
    logic [SLOT_W-1:0] r_nxt_mem [CAPACITY];
    logic [DATA_W-1:0] r_val_rdata;
    logic [SLOT_W-1:0] r_nxt_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        r_val_rdata <= r_val_mem[i_req.val_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.nxt_we) begin
            r_nxt_mem[i_req.nxt_waddr] <= i_req.nxt_wdata;
        end
        r_nxt_rdata <= r_nxt_mem[i_req.nxt_raddr];
    end

    assign o_val_rdata = r_val_rdata;
    assign o_nxt_rdata = r_nxt_rdata;

endmodule

// ===== sv/cle_checker.sv =====
// port-level checks for the circular list engine, bound to the top level
// depends on cle_pkg and circular_list_engine_assert.svh
`include "circular_list_engine_assert.svh"

module cle_checker import cle_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic [ACTION_W-1:0]      i_action,
    input logic signed [DATA_W-1:0] i_value,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [STATUS_W-1:0]      o_status,
    input logic [COUNT_W-1:0]       o_count,
    input logic signed [DATA_W-1:0] o_head_value,
    input logic signed [DATA_W-1:0] o_tail_value,
    input logic                     o_is_empty
);

    `CLE_ASSERT_IMP(a_empty_flag, o_out_valid, o_is_empty == (o_count == '0), "empty flag disagrees with count")
    `CLE_ASSERT_IMP(a_empty_zero, o_out_valid && o_is_empty, o_head_value == '0 && o_tail_value == '0, "empty list shows nonzero values")
    `CLE_ASSERT_IMP(a_single_node, o_out_valid && o_count == COUNT_W'(1), o_head_value == o_tail_value, "single node head and tail differ")
    `CLE_ASSERT_IMP(a_full_count, o_out_valid && o_status == ST_FULL, o_count == COUNT_W'(CAPACITY), "pool full reported below capacity")
    `CLE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_count) && $stable(o_head_value), "stalled result beat changed")

endmodule

bind circular_list_engine cle_checker u_cle_checker (.*);

// ===== dv/circular_list_engine_tb.sv =====
// self-checking testbench for circular_list_engine: directed and random list operations
// drives both valid/ready channels and checks every result beat against a list tracker
// depends on cle_pkg and the circular_list_engine rtl
module circular_list_engine_tb;
    import cle_pkg::*;

    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT      = 4_000_000;

    localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_ZERO = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] VAL_ONES = 32'shffff_ffff;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    typedef struct {
        t_status                   status;
        logic [COUNT_W-1:0]        count;
        logic signed [DATA_W-1:0]  head_value;
        logic signed [DATA_W-1:0]  tail_value;
        logic                      is_empty;
    } t_list_report;

    class cle_list_tracker;
        logic signed [DATA_W-1:0] list_vals[$];
        t_list_report             report_q[$];
        int                       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void apply_op(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value);
            t_list_report r;
            int           idx;
            r.status = ST_DONE;
            idx = -1;
            case (action)
                ACT_INS_HEAD, ACT_INS_TAIL: begin
                    if (list_vals.size() >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else if (action == ACT_INS_HEAD) begin
                        list_vals.push_front(value);
                    end else begin
                        list_vals.push_back(value);
                    end
                end
                ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_VALUE: begin
                    if (list_vals.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else if (action == ACT_DEL_HEAD) begin
                        void'(list_vals.pop_front());
                    end else if (action == ACT_DEL_TAIL) begin
                        void'(list_vals.pop_back());
                    end else begin
                        foreach (list_vals[i]) begin
                            if (idx < 0 && list_vals[i] == value) begin
                                idx = i;
                            end
                        end
                        if (idx < 0) begin
                            r.status = ST_NOT_FOUND;
                        end else begin
                            list_vals.delete(idx);
                        end
                    end
                end
                default: ;
            endcase
            r.count      = COUNT_W'(list_vals.size());
            r.is_empty   = (list_vals.size() == 0);
            r.head_value = r.is_empty ? VAL_ZERO : list_vals[0];
            r.tail_value = r.is_empty ? VAL_ZERO : list_vals[$];
            report_q.push_back(r);
        endfunction

        function void flag(string field, longint exp_v, longint act_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            mismatches++;
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                                   logic signed [DATA_W-1:0] head_value,
                                   logic signed [DATA_W-1:0] tail_value, logic is_empty);
            t_list_report r;
            if (report_q.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none, actual status %0d",
                         $time, status);
                mismatches++;
                return;
            end
            r = report_q.pop_front();
            if (status !== r.status) flag("status", r.status, status);
            if (count !== r.count) flag("count", r.count, count);
            if (head_value !== r.head_value) flag("head_value", r.head_value, head_value);
            if (tail_value !== r.tail_value) flag("tail_value", r.tail_value, tail_value);
            if (is_empty !== r.is_empty) flag("is_empty", r.is_empty, is_empty);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [ACTION_W-1:0]       i_action;
    logic signed [DATA_W-1:0]  i_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [STATUS_W-1:0]       o_status;
    logic [COUNT_W-1:0]        o_count;
    logic signed [DATA_W-1:0]  o_head_value;
    logic signed [DATA_W-1:0]  o_tail_value;
    logic                      o_is_empty;

    cle_list_tracker tracker = new();
    bit              no_idle = 1'b0;

    circular_list_engine i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_head_value (o_head_value),
        .o_tail_value (o_tail_value),
        .o_is_empty   (o_is_empty)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_beat(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.apply_op(action, value);
    endtask

    // hold off the sender until every pending result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.report_q.size() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return $signed($urandom_range(0, 9)) - 4;
        end else if (roll < 7) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_ZERO;
                default: return VAL_ONES;
            endcase
        end
        return $signed($urandom());
    endfunction

    task automatic send_random(int mode);
        int                        roll;
        int                        ins_pct;
        logic [ACTION_W-1:0]       action;
        logic signed [DATA_W-1:0]  value;
        roll    = $urandom_range(0, 99);
        ins_pct = (mode == MODE_GROW) ? 75 : (mode == MODE_SHRINK) ? 25 : 50;
        if (roll < 3) begin
            action = ACTION_W'($urandom_range(ACT_DEL_VALUE + 1, (1 << ACTION_W) - 1));
        end else if (roll < ins_pct) begin
            action = $urandom_range(0, 1) ? ACT_INS_TAIL : ACT_INS_HEAD;
        end else begin
            case ($urandom_range(0, 2))
                0: action = ACT_DEL_HEAD;
                1: action = ACT_DEL_TAIL;
                default: action = ACT_DEL_VALUE;
            endcase
        end
        if (action == ACT_DEL_VALUE && tracker.list_vals.size() != 0
            && $urandom_range(0, 3) != 0) begin
            value = tracker.list_vals[$urandom_range(0, tracker.list_vals.size() - 1)];
        end else begin
            value = pick_value();
        end
        send_beat(action, value);
    endtask

    // result side
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_result(o_status, o_count, o_head_value, o_tail_value, o_is_empty);
        end
    end

    initial begin
        int sent;
        int seg_len;
        int mode;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_INS_HEAD;
        i_value    <= VAL_ZERO;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // deletes and unused codes on an empty list, then four inserts and an unused code
        send_beat(ACT_DEL_HEAD, VAL_ZERO);
        send_beat(ACT_DEL_TAIL, VAL_ZERO);
        send_beat(ACT_DEL_VALUE, VAL_ONES);
        send_beat(ACTION_W'(ACT_DEL_VALUE + 1), VAL_MAX);
        send_beat(ACTION_W'((1 << ACTION_W) - 1), VAL_MIN);
        send_beat(ACT_INS_HEAD, VAL_MIN);
        send_beat(ACT_INS_TAIL, VAL_MAX);
        send_beat(ACT_INS_HEAD, VAL_ZERO);
        send_beat(ACT_INS_TAIL, VAL_ONES);
        send_beat(ACTION_W'(ACT_DEL_VALUE + 2), VAL_ONES);
        // no match, then matches in the middle, at the tail and at the head
        send_beat(ACT_DEL_VALUE, 32'sd12345);
        send_beat(ACT_DEL_VALUE, VAL_MAX);
        send_beat(ACT_DEL_VALUE, VAL_ONES);
        send_beat(ACT_DEL_VALUE, VAL_ZERO);
        // last node removed from the tail
        send_beat(ACT_DEL_TAIL, VAL_ZERO);
        send_beat(ACT_INS_TAIL, 32'sh5555_5555);
        send_beat(ACT_INS_HEAD, 32'shaaaa_aaaa);
        send_beat(ACT_DEL_TAIL, VAL_ZERO);
        send_beat(ACT_DEL_HEAD, VAL_ZERO);
        send_beat(ACT_INS_HEAD, 32'sd1);
        send_beat(ACT_DEL_VALUE, 32'sd1);
        wait_drained();

        // random segments that grow, shrink or churn the list
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 60);
            mode    = $urandom_range(MODE_GROW, MODE_MIX);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                send_random(mode);
                sent++;
            end
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.report_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cle_pkg.sv
sv/cle_node_mem.sv
sv/circular_list_engine.sv
sv/cle_checker.sv
dv/circular_list_engine_tb.sv
